[hw/rtl/slb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the S-box lookup and linear bias block.
// No dependencies; imported by slb_cell and sbox_lookup_and_linear_bias.

package slb_pkg;

    // Field widths of the stream payload
    localparam int FIELD_W      = 4;
    localparam int S_TDATA_W    = 16;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 16;

    // Default table geometry
    localparam int DEF_IN_BITS  = 4;
    localparam int DEF_OUT_BITS = 4;

    // Request kinds, carried on the slave tuser
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FWD  = 2'd1,
        OP_INV  = 2'd2,
        OP_BIAS = 2'd3
    } t_op;

    // Token control moving down the cell chain
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

endpackage

[hw/rtl/slb_cell.sv]
`timescale 1ns / 1ps
// One cell of the S-box chain: holds the table entry for its own index and
// works on the token passing through. Depends on slb_pkg.

module slb_cell #(
    parameter int IN_BITS  = slb_pkg::DEF_IN_BITS,
    parameter int OUT_BITS = slb_pkg::DEF_OUT_BITS,
    parameter int ACC_W    = slb_pkg::DEF_IN_BITS + 1,
    parameter int INDEX    = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slb_pkg::t_ctl        i_ctl,
    input  logic [OUT_BITS-1:0]  i_key,
    input  logic [IN_BITS-1:0]   i_amask,
    input  logic [OUT_BITS-1:0]  i_bmask,
    input  logic [ACC_W-1:0]     i_acc,
    input  logic                 i_flag,
    output slb_pkg::t_ctl        o_ctl,
    output logic [OUT_BITS-1:0]  o_key,
    output logic [IN_BITS-1:0]   o_amask,
    output logic [OUT_BITS-1:0]  o_bmask,
    output logic [ACC_W-1:0]     o_acc,
    output logic                 o_flag
);
    import slb_pkg::*;

    localparam logic [IN_BITS-1:0] MY_IDX = IN_BITS'(INDEX);

    logic [OUT_BITS-1:0] r_entry;
    t_ctl                r_ctl;
    logic [OUT_BITS-1:0] r_key;
    logic [IN_BITS-1:0]  r_amask;
    logic [OUT_BITS-1:0] r_bmask;
    logic [ACC_W-1:0]    r_acc;
    logic                r_flag;

    logic [ACC_W-1:0]    n_acc;
    logic                n_flag;
    logic                n_we;
    logic                w_match;

    // Linear relation holds when both masked parities agree
    assign w_match = ((^(MY_IDX & i_amask)) == (^(r_entry & i_bmask)));

    // Per-request work on the passing token
    always_comb begin
        n_acc  = i_acc;
        n_flag = i_flag;
        n_we   = 1'b0;
        case (i_ctl.op)
            OP_LOAD: begin
                // acc carries the load index, key the new value
                if (i_acc[IN_BITS-1:0] == MY_IDX) begin
                    n_we = i_ctl.valid;
                end
                if ((MY_IDX < i_acc[IN_BITS-1:0]) && (r_entry == i_key)) begin
                    n_flag = 1'b1;
                end
            end
            OP_FWD: begin
                // amask carries the index to look up
                if (i_amask == MY_IDX) begin
                    n_acc = ACC_W'(r_entry);
                end
            end
            OP_INV: begin
                // later cells override, so the highest matching index wins
                if (r_entry == i_key) begin
                    n_acc  = ACC_W'(MY_IDX);
                    n_flag = 1'b1;
                end
            end
            OP_BIAS: begin
                n_acc = i_acc + ACC_W'(w_match);
            end
            default: begin
                n_acc = i_acc;
            end
        endcase
    end

    // Token register and entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_key   <= i_key;
        r_amask <= i_amask;
        r_bmask <= i_bmask;
        r_acc   <= n_acc;
        r_flag  <= n_flag;
        if (n_we) begin
            r_entry <= i_key;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_key   = r_key;
    assign o_amask = r_amask;
    assign o_bmask = r_bmask;
    assign o_acc   = r_acc;
    assign o_flag  = r_flag;

endmodule

[hw/rtl/sbox_lookup_and_linear_bias.sv]
`timescale 1ns / 1ps
// Top level of the S-box lookup and linear bias block: request intake, the
// chain of slb_cell, load bookkeeping and the result register. Uses slb_pkg.
//
//  Port group     | Dir | tdata fields (low bit up)                 | tuser
//  s_axis_*       | in  | entry_value, lookup_value, input_mask,    | operation
//                 |     | output_mask (4 bits each)                 |
//  m_axis_*       | out | result_value(4), bias_numerator(4),       | -
//                 |     | table_complete(1), not_invertible(1), 0s  |
//
// Every request walks the whole chain of 2^IN_BITS cells, one cell a cycle;
// the result then waits in a pending register for the output register.
// One request is in flight at a time; the next is taken once the result
// sits in the output register, even if the master side is stalled.
// Synchronous active-low reset clears the flags and load index; table
// entries are unknown until loaded.

module sbox_lookup_and_linear_bias #(
    parameter int IN_BITS  = slb_pkg::DEF_IN_BITS,
    parameter int OUT_BITS = slb_pkg::DEF_OUT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // entry_value[3:0], lookup_value[7:4], input_mask[11:8], output_mask[15:12]
    input  logic [slb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [slb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_value[3:0], bias_numerator[7:4], table_complete[8],
    // not_invertible[9], zero[15:10]
    output logic [slb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import slb_pkg::*;

    localparam int N     = 1 << IN_BITS;
    localparam int ACC_W = (IN_BITS + 1 > OUT_BITS) ? IN_BITS + 1 : OUT_BITS;
    localparam int PAD_W = M_TDATA_W - 2 * FIELD_W - 2;
    localparam logic [IN_BITS-1:0] LAST_IDX = IN_BITS'(N - 1);
    localparam logic [IN_BITS:0]   HALF     = (IN_BITS + 1)'(N / 2);

    // Chain wiring: element 0 is the intake, element N the chain exit
    t_ctl                w_ctl   [0:N];
    logic [OUT_BITS-1:0] w_key   [0:N];
    logic [IN_BITS-1:0]  w_amask [0:N];
    logic [OUT_BITS-1:0] w_bmask [0:N];
    logic [ACC_W-1:0]    w_acc   [0:N];
    logic                w_flag  [0:N];
    logic [N-1:0]        w_chain_valid;

    logic [FIELD_W-1:0]  w_entry_f, w_look_f, w_amask_f, w_bmask_f;
    t_op                 w_in_op;
    logic                w_in_xfer;

    // Control and status registers
    logic [IN_BITS-1:0]  r_load_idx, n_load_idx;
    logic                r_full, n_full;
    logic                r_dup, n_dup;
    logic                r_inflight;
    logic                r_pend_valid;
    logic [FIELD_W-1:0]  r_pend_res, n_res;
    logic [FIELD_W-1:0]  r_pend_bias, n_bias;
    logic                r_pend_full, r_pend_dup;
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic                w_exit;
    logic [IN_BITS:0]    w_count;
    logic [IN_BITS:0]    w_diff;
    logic                w_out_free;

    // Unpack the slave transfer
    assign w_entry_f = s_axis_tdata[FIELD_W-1:0];
    assign w_look_f  = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign w_amask_f = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
    assign w_bmask_f = s_axis_tdata[4*FIELD_W-1:3*FIELD_W];
    assign w_in_op   = t_op'(s_axis_tuser);

    assign s_axis_tready = !r_inflight && !r_pend_valid;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // Token launched into the first cell
    always_comb begin
        w_ctl[0].valid = w_in_xfer;
        w_ctl[0].op    = w_in_op;
        w_key[0]       = OUT_BITS'(w_look_f);
        w_amask[0]     = IN_BITS'(w_amask_f);
        w_bmask[0]     = OUT_BITS'(w_bmask_f);
        w_acc[0]       = '0;
        w_flag[0]      = 1'b0;
        case (w_in_op)
            OP_LOAD: begin
                w_key[0] = OUT_BITS'(w_entry_f);
                w_acc[0] = ACC_W'(r_load_idx);
            end
            OP_FWD: begin
                w_amask[0] = IN_BITS'(w_look_f);
            end
            default: begin
                w_key[0] = OUT_BITS'(w_look_f);
            end
        endcase
    end

    // Row of cells, one per table index
    for (genvar g = 0; g < N; g++) begin : g_cell
        slb_cell #(
            .IN_BITS  (IN_BITS),
            .OUT_BITS (OUT_BITS),
            .ACC_W    (ACC_W),
            .INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_key   (w_key[g]),
            .i_amask (w_amask[g]),
            .i_bmask (w_bmask[g]),
            .i_acc   (w_acc[g]),
            .i_flag  (w_flag[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_key   (w_key[g+1]),
            .o_amask (w_amask[g+1]),
            .o_bmask (w_bmask[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_flag  (w_flag[g+1])
        );
        assign w_chain_valid[g] = w_ctl[g+1].valid;
    end

    assign w_exit = w_ctl[N].valid;

    // Bias magnitude from the match count
    assign w_count = w_acc[N][IN_BITS:0];
    assign w_diff  = (w_count >= HALF) ? (w_count - HALF) : (HALF - w_count);

    // Load bookkeeping and result fields at chain exit
    always_comb begin
        n_load_idx = r_load_idx;
        n_full     = r_full;
        n_dup      = r_dup;
        n_res      = '0;
        n_bias     = '0;
        case (w_ctl[N].op)
            OP_LOAD: begin
                n_load_idx = r_load_idx + 1'b1;
                n_dup      = ((r_load_idx == '0) ? 1'b0 : r_dup) | w_flag[N];
                if (r_load_idx == LAST_IDX) begin
                    n_full = 1'b1;
                end else if (r_load_idx == '0) begin
                    n_full = 1'b0;
                end
            end
            OP_FWD, OP_INV: begin
                if (r_full) begin
                    n_res = FIELD_W'(w_acc[N]);
                end
            end
            OP_BIAS: begin
                if (r_full) begin
                    n_bias = FIELD_W'(w_diff);
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Control state, pending result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx   <= '0;
            r_full       <= 1'b0;
            r_dup        <= 1'b0;
            r_inflight   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_inflight <= 1'b1;
            end else if (w_exit) begin
                r_inflight <= 1'b0;
            end

            if (w_exit) begin
                r_pend_valid <= 1'b1;
                if (w_ctl[N].op == OP_LOAD) begin
                    r_load_idx <= n_load_idx;
                    r_full     <= n_full;
                    r_dup      <= n_dup;
                end
            end else if (r_pend_valid && w_out_free) begin
                r_pend_valid <= 1'b0;
            end

            if (r_pend_valid && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_exit) begin
            r_pend_res  <= n_res;
            r_pend_bias <= n_bias;
            r_pend_full <= n_full;
            r_pend_dup  <= n_dup;
        end
        if (r_pend_valid && w_out_free) begin
            r_out_data <= {{PAD_W{1'b0}}, r_pend_dup, r_pend_full,
                           r_pend_bias, r_pend_res};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks on the sequencing of the chain
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_chain_valid) <= 1)
        else $error("more than one token in the cell chain");

    a_exit_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit |-> r_inflight)
        else $error("chain exit without a request in flight");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_out_valid && !m_axis_tready) |=> r_pend_valid)
        else $error("pending result dropped while output stalled");

    a_full_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_load_idx == '0))
        else $error("table complete with a partial load index");

endmodule
